### design/frequency_presence_monitor_top_assert.svh
// Assertion macros for the frequency presence monitor.
`ifndef FREQUENCY_PRESENCE_MONITOR_TOP_ASSERT_SVH
`define FREQUENCY_PRESENCE_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define FPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frequency presence monitor check failed");

// Next-cycle implication, quiet during reset.
`define FPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frequency presence monitor check failed");

`endif

### design/fpm_pkg.sv
`timescale 1ns / 1ps

package fpm_pkg;

  localparam int FREQ_BITS        = 24;
  localparam int LIMIT_BITS       = 16;
  localparam int CV_BITS          = 16;
  localparam int TIME_BITS        = 32;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int ADDR_BITS        = 5;
  localparam int DATA_BITS        = 32;

  localparam logic [LIMIT_BITS-1:0] BAD_MAX = 16'hFFFF;

  localparam logic [FREQ_BITS-1:0]  TARGET_RST   = 24'd100;
  localparam logic [FREQ_BITS-1:0]  TOL_RST      = 24'd5;
  localparam logic [FREQ_BITS-1:0]  TIMER_RST    = 24'd100000;
  localparam logic [LIMIT_BITS-1:0] TIMEOUT_RST  = 16'd100;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RST    = 16'd100;
  localparam logic [LIMIT_BITS-1:0] INTERVAL_RST = 16'd1000;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_TOL      = 3'd1,
    REG_TIMER    = 3'd2,
    REG_TIMEOUT  = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_INTERVAL = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_CAPTURE  = 1'b0,
    OP_EVALUATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EV_WIN,
    ST_EV_CNT,
    ST_EV_DEC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 op;
    logic [CV_BITS-1:0]   counter_value;
    logic [TIME_BITS-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0]  measured_freq_hz;
    logic                  timed_out;
    logic [LIMIT_BITS-1:0] bad_count;
    logic                  sleep_request;
    logic [CV_BITS-1:0]    next_compare;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/fpm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
module fpm_div #(
  parameter int COUNTER_BITS = fpm_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fpm_pkg::FREQ_BITS-1:0]  dividend,
  input  logic [COUNTER_BITS-1:0]        divisor,
  output logic [fpm_pkg::FREQ_BITS-1:0]  quotient,
  output fpm_pkg::div_stat_t             stat
);

  localparam int STEP_BITS = $clog2(fpm_pkg::FREQ_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(fpm_pkg::FREQ_BITS - 1);

  logic                          busy;
  logic                          done;
  logic [STEP_BITS-1:0]          step;
  logic [fpm_pkg::FREQ_BITS-1:0] dvd;
  logic [COUNTER_BITS-1:0]       rem;
  logic [COUNTER_BITS-1:0]       dsr;
  logic [COUNTER_BITS:0]         sh;
  logic [COUNTER_BITS+1:0]       trial;
  logic                          borrow;

  assign sh     = {rem, dvd[fpm_pkg::FREQ_BITS-1]};
  assign trial  = {1'b0, sh} - {2'b00, dsr};
  assign borrow = trial[COUNTER_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      // shift quotient bit in as the dividend bit leaves
      dvd <= {dvd[fpm_pkg::FREQ_BITS-2:0], ~borrow};
      rem <= borrow ? sh[COUNTER_BITS-1:0] : trial[COUNTER_BITS-1:0];
    end
  end

  assign quotient  = dvd;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/frequency_presence_monitor_top.sv
`timescale 1ns / 1ps
// Frequency presence monitor. Each beat on the evt channel is either a capture
// (op=0, counter latched at a signal edge) or an evaluation (op=1, current
// counter and millisecond time), and each produces exactly one result beat.
// A capture that yields a nonzero period runs a bit-serial restoring divide of
// timer_clock_hz by the period, one quotient bit per cycle, and the quotient
// is then loaded into the output register. A first capture, a capture with
// zero period, and any item after sleep go straight to the output load; an
// evaluation steps through window, count, decision and load. The input side
// takes one item at a time; the result sits in an output register, so the
// next item is accepted while the previous result waits.
// Registers sit on an APB-style port at byte address 4*index, pready tied high;
// write them only while the block is idle.

`include "frequency_presence_monitor_top_assert.svh"

module frequency_presence_monitor_top #(
  parameter int COUNTER_BITS = fpm_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_stall,
  input  fpm_pkg::evt_t                 evt,
  output logic                          res_valid,
  input  logic                          res_stall,
  output fpm_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [fpm_pkg::DATA_BITS-1:0] pwdata,
  output logic [fpm_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int FB = fpm_pkg::FREQ_BITS;
  localparam int LB = fpm_pkg::LIMIT_BITS;
  localparam int CB = fpm_pkg::CV_BITS;
  localparam int TB = fpm_pkg::TIME_BITS;

  // Counter values narrower than the field keep only their low COUNTER_BITS.
  localparam logic [CB-1:0] CV_MASK = (COUNTER_BITS >= CB) ? {CB{1'b1}}
                                    : CB'((33'd1 << COUNTER_BITS) - 33'd1);
  localparam logic [CB:0]   CMP_MASK = (COUNTER_BITS > CB) ? {(CB+1){1'b1}}
                                     : (CB+1)'((33'd1 << COUNTER_BITS) - 33'd1);

  // ---------------------------------------------------------------- config
  logic [FB-1:0] freq_center;
  logic [FB-1:0] freq_margin;
  logic [FB-1:0] timer_clock_hz;
  logic [LB-1:0] edge_timeout;
  logic [LB-1:0] bad_limit;
  logic [LB-1:0] eval_interval_counts;

  fpm_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = fpm_pkg::reg_idx_t'(paddr[fpm_pkg::ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_center          <= fpm_pkg::TARGET_RST;
      freq_margin          <= fpm_pkg::TOL_RST;
      timer_clock_hz       <= fpm_pkg::TIMER_RST;
      edge_timeout         <= fpm_pkg::TIMEOUT_RST;
      bad_limit            <= fpm_pkg::LIMIT_RST;
      eval_interval_counts <= fpm_pkg::INTERVAL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        fpm_pkg::REG_TARGET:   freq_center          <= pwdata[FB-1:0];
        fpm_pkg::REG_TOL:      freq_margin          <= pwdata[FB-1:0];
        fpm_pkg::REG_TIMER:    timer_clock_hz       <= pwdata[FB-1:0];
        fpm_pkg::REG_TIMEOUT:  edge_timeout         <= pwdata[LB-1:0];
        fpm_pkg::REG_LIMIT:    bad_limit            <= pwdata[LB-1:0];
        fpm_pkg::REG_INTERVAL: eval_interval_counts <= pwdata[LB-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fpm_pkg::REG_TARGET:   prdata = 32'(freq_center);
      fpm_pkg::REG_TOL:      prdata = 32'(freq_margin);
      fpm_pkg::REG_TIMER:    prdata = 32'(timer_clock_hz);
      fpm_pkg::REG_TIMEOUT:  prdata = 32'(edge_timeout);
      fpm_pkg::REG_LIMIT:    prdata = 32'(bad_limit);
      fpm_pkg::REG_INTERVAL: prdata = 32'(eval_interval_counts);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  fpm_pkg::state_t state;
  fpm_pkg::state_t state_next;

  logic          first_seen;
  logic [CB-1:0] prev_capture;
  logic [TB-1:0] last_edge_ms;
  logic [FB-1:0] freq_value;
  logic [LB-1:0] bad_counter;
  logic          halted;
  logic [CB-1:0] compare_value;

  // working copies of the evaluation item
  logic [CB-1:0] cv_hold;
  logic [TB-1:0] now_hold;
  logic          lost;
  logic [FB-1:0] win_lo;
  logic [FB:0]   win_hi;

  logic          evt_take;
  logic          res_take;
  logic [CB-1:0] cv_in;
  logic [32:0]   diff_full;
  logic [COUNTER_BITS-1:0] period;
  logic          period_zero;
  logic          div_start;
  logic          res_load;

  logic [FB-1:0]       div_q;
  fpm_pkg::div_stat_t  div_stat;

  logic [TB-1:0] elapsed;
  logic          lost_now;
  logic          good;
  logic [CB:0]   cmp_sum;
  logic [CB:0]   cmp_wrap;

  assign evt_stall = (state != fpm_pkg::ST_IDLE);
  assign evt_take  = evt_valid && !evt_stall;
  assign res_take  = res_valid && !res_stall;

  assign cv_in       = evt.counter_value & CV_MASK;
  assign diff_full   = {17'b0, cv_in} - {17'b0, prev_capture};
  assign period      = diff_full[COUNTER_BITS-1:0];
  assign period_zero = (period == '0);

  assign elapsed  = now_hold - last_edge_ms;
  assign lost_now = !first_seen || (elapsed > TB'(edge_timeout));
  assign good     = !lost && (freq_value >= win_lo) && ({1'b0, freq_value} <= win_hi);
  assign cmp_sum  = {1'b0, cv_hold} + {1'b0, eval_interval_counts};
  assign cmp_wrap = cmp_sum & CMP_MASK;

  fpm_div #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timer_clock_hz),
    .divisor  (period),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_load   = 1'b0;
    case (state)
      fpm_pkg::ST_IDLE: begin
        if (evt_take) begin
          if (halted) begin
            state_next = fpm_pkg::ST_FINISH;
          end else if (evt.op == fpm_pkg::OP_EVALUATE) begin
            state_next = fpm_pkg::ST_EV_WIN;
          end else if (first_seen && !period_zero) begin
            div_start  = 1'b1;
            state_next = fpm_pkg::ST_DIV;
          end else begin
            state_next = fpm_pkg::ST_FINISH;
          end
        end
      end
      fpm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = fpm_pkg::ST_FINISH;
        end
      end
      fpm_pkg::ST_EV_WIN: state_next = fpm_pkg::ST_EV_CNT;
      fpm_pkg::ST_EV_CNT: state_next = fpm_pkg::ST_EV_DEC;
      fpm_pkg::ST_EV_DEC: state_next = fpm_pkg::ST_FINISH;
      fpm_pkg::ST_FINISH: begin
        // hold until the output register is free or is being taken
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = fpm_pkg::ST_IDLE;
        end
      end
      default: state_next = fpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // monitor state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen    <= 1'b0;
      prev_capture  <= '0;
      last_edge_ms  <= '0;
      freq_value    <= '0;
      bad_counter   <= '0;
      halted        <= 1'b0;
      compare_value <= '0;
    end else begin
      case (state)
        fpm_pkg::ST_IDLE: begin
          if (evt_take && !halted && evt.op == fpm_pkg::OP_CAPTURE) begin
            last_edge_ms <= evt.now_ms;
            prev_capture <= cv_in;
            if (!first_seen) begin
              first_seen <= 1'b1;
            end else if (period_zero) begin
              // re-arm: this capture becomes the new reference
              first_seen <= 1'b0;
              freq_value <= '0;
            end
          end
        end
        fpm_pkg::ST_DIV: begin
          if (div_stat.done) begin
            freq_value <= div_q;
          end
        end
        fpm_pkg::ST_EV_WIN: begin
          if (lost_now) begin
            freq_value <= '0;
            first_seen <= 1'b0;
          end
        end
        fpm_pkg::ST_EV_CNT: begin
          if (good) begin
            bad_counter <= '0;
          end else if (bad_counter != fpm_pkg::BAD_MAX) begin
            bad_counter <= bad_counter + 1'b1;
          end
        end
        fpm_pkg::ST_EV_DEC: begin
          if (bad_counter >= bad_limit) begin
            halted <= 1'b1;
          end else begin
            compare_value <= cmp_wrap[CB-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (evt_take) begin
      cv_hold  <= cv_in;
      now_hold <= evt.now_ms;
      lost     <= 1'b0;
    end else if (state == fpm_pkg::ST_EV_WIN) begin
      lost   <= lost_now;
      win_lo <= (freq_margin > freq_center) ? '0
              : freq_center - freq_margin;
      win_hi <= {1'b0, freq_center} + {1'b0, freq_margin};
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.measured_freq_hz <= freq_value;
      res.timed_out        <= lost;
      res.bad_count        <= bad_counter;
      res.sleep_request    <= halted;
      res.next_compare     <= compare_value;
    end
  end

  // ---------------------------------------------------------------- checks
  `FPM_ASSERT_NEXT(a_halt_sticky, halted, halted)
  `FPM_ASSERT_NOW(a_div_only_in_div, div_stat.busy, state == fpm_pkg::ST_DIV)
  `FPM_ASSERT_NOW(a_timeout_zero_freq, res_valid && res.timed_out, res.measured_freq_hz == '0)

endmodule
